// File: hw/rtl/srrm_pkg.sv
// Shared types and constants of the staged range remap block.
`default_nettype none

package srrm_pkg;

  // Default sizes of the remap table and of the value path.
  localparam int STAGES_DEF         = 7;
  localparam int ENTRIES_DEF        = 64;
  localparam int VALUE_BITS_DEF     = 32;

  // Field widths of a request and of a result.
  localparam int CMD_W              = 2;
  localparam int STAGE_W            = 3;
  localparam int SLOT_W             = 6;
  localparam int FIELD_W            = 32;

  // Bit positions of the request fields in s_tdata.
  localparam int STAGE_LSB          = 0;
  localparam int SLOT_LSB           = STAGE_LSB + STAGE_W;
  localparam int DEST_LSB           = SLOT_LSB + SLOT_W;
  localparam int SRC_LSB            = DEST_LSB + FIELD_W;
  localparam int LEN_LSB            = SRC_LSB + FIELD_W;
  localparam int VALUE_LSB          = LEN_LSB + FIELD_W;
  localparam int S_PAYLOAD_W        = VALUE_LSB + FIELD_W;
  localparam int S_TDATA_W          = ((S_PAYLOAD_W + 7) / 8) * 8;
  localparam int M_TDATA_W          = 2 * FIELD_W;

  // Request kinds carried in s_tuser.
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_XLATE = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/staged_range_remap_min_top.sv
// Staged range remap with running minimum: sequencer, entry table and one shared comparator.
`default_nettype none

// A value is translated through STAGES remap stages of ENTRIES_PER_STAGE entries each.
// The entries sit in one single-port table memory, and a single window comparator
// examines one entry per cycle, so a translate request walks the table entry by entry,
// finishing sooner when a stage matches early, since the rest of that stage is skipped.
// After reset and after each clear request the table is swept once to drop its valid
// marks, one entry at a time, during which no request is taken. s_tready is high
// only while the sequencer is idle; a result waits in the output register until it
// is taken, and further requests are accepted meanwhile.
module staged_range_remap_min_top #(
  parameter int STAGES            = srrm_pkg::STAGES_DEF,
  parameter int ENTRIES_PER_STAGE = srrm_pkg::ENTRIES_DEF,
  parameter int VALUE_BITS        = srrm_pkg::VALUE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // stage[2:0], slot[8:3], dest_start[40:9], src_start[72:41],
  // window_len[104:73], value[136:105], zero fill above
  input  wire logic [srrm_pkg::S_TDATA_W-1:0] s_tdata,
  // command[1:0]
  input  wire logic [srrm_pkg::CMD_W-1:0]     s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // mapped_value[31:0], running_min[63:32]
  output logic [srrm_pkg::M_TDATA_W-1:0]      m_tdata
);

  import srrm_pkg::*;

  localparam int DEPTH = STAGES * ENTRIES_PER_STAGE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AW1   = $clog2(DEPTH + 1);
  localparam int SLW   = (ENTRIES_PER_STAGE > 1) ? $clog2(ENTRIES_PER_STAGE) : 1;

  typedef struct packed {
    logic                  valid;
    logic [VALUE_BITS-1:0] dest;
    logic [VALUE_BITS-1:0] src;
    logic [VALUE_BITS-1:0] len;
  } entry_t;

  // Request fields.
  cmd_t                in_cmd;
  logic [STAGE_W-1:0]  in_stage;
  logic [SLOT_W-1:0]   in_slot;
  logic [FIELD_W-1:0]  in_dest;
  logic [FIELD_W-1:0]  in_src;
  logic [FIELD_W-1:0]  in_len;
  logic [FIELD_W-1:0]  in_value;
  logic                in_accept;
  logic                in_range;

  // Sequencer and datapath registers.
  state_t              state, state_next;
  logic [AW1-1:0]      iss_addr, iss_addr_next;
  logic [SLW-1:0]      iss_slot, iss_slot_next;
  logic                rd_pend, rd_pend_next;
  logic [AW1-1:0]      rd_addr, rd_addr_next;
  logic [SLW-1:0]      rd_slot, rd_slot_next;
  entry_t              rd_entry;
  logic [VALUE_BITS-1:0] cur, cur_next;
  logic [VALUE_BITS-1:0] lowest, lowest_next;
  logic                out_valid, out_valid_next;
  logic [VALUE_BITS-1:0] out_mapped, out_mapped_next;
  logic [VALUE_BITS-1:0] out_min, out_min_next;

  // Table memory ports.
  entry_t              mem [DEPTH];
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  entry_t              mem_wdata;
  logic                mem_re;

  // Comparator.
  logic [VALUE_BITS:0]   win_end;
  logic                  hit;
  logic [VALUE_BITS-1:0] hit_value;
  logic                  scan_issue;
  logic                  scan_done;
  logic                  out_free;
  logic [VALUE_BITS-1:0] min_new;

  // Unpack the request.
  assign in_cmd    = cmd_t'(s_tuser);
  assign in_stage  = s_tdata[STAGE_LSB +: STAGE_W];
  assign in_slot   = s_tdata[SLOT_LSB +: SLOT_W];
  assign in_dest   = s_tdata[DEST_LSB +: FIELD_W];
  assign in_src    = s_tdata[SRC_LSB +: FIELD_W];
  assign in_len    = s_tdata[LEN_LSB +: FIELD_W];
  assign in_value  = s_tdata[VALUE_LSB +: FIELD_W];
  assign in_accept = s_tvalid && s_tready;
  assign in_range  = (int'(in_stage) < STAGES) && (int'(in_slot) < ENTRIES_PER_STAGE);

  // Window compare on the entry read last cycle; the window end never wraps.
  assign win_end   = {1'b0, rd_entry.src} + {1'b0, rd_entry.len};
  assign hit       = rd_pend && rd_entry.valid && (cur >= rd_entry.src) &&
                     ({1'b0, cur} < win_end);
  assign hit_value = cur - rd_entry.src + rd_entry.dest;

  assign scan_issue = (iss_addr != AW1'(DEPTH));
  assign scan_done  = !scan_issue && !rd_pend;
  assign out_free   = !out_valid || m_tready;
  assign min_new    = (cur < lowest) ? cur : lowest;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (iss_addr == AW1'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (in_cmd)
            CMD_XLATE: state_next = ST_SCAN;
            CMD_CLEAR: state_next = ST_CLEAR;
            default:   state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (scan_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    s_tready = (state == ST_IDLE);
    m_tvalid = out_valid;
    m_tdata  = {FIELD_W'(out_min), FIELD_W'(out_mapped)};
  end

  // Datapath and table port control.
  always_comb begin
    iss_addr_next   = iss_addr;
    iss_slot_next   = iss_slot;
    rd_pend_next    = rd_pend;
    rd_addr_next    = rd_addr;
    rd_slot_next    = rd_slot;
    cur_next        = cur;
    lowest_next     = lowest;
    out_valid_next  = out_valid && !m_tready;
    out_mapped_next = out_mapped;
    out_min_next    = out_min;
    mem_we          = 1'b0;
    mem_waddr       = iss_addr[AW-1:0];
    mem_wdata       = '0;
    mem_re          = 1'b0;
    case (state)
      ST_CLEAR: begin
        // Sweep the table, dropping one valid mark per cycle.
        mem_we        = 1'b1;
        iss_addr_next = iss_addr + AW1'(1);
      end
      ST_IDLE: begin
        if (in_accept) begin
          case (in_cmd)
            CMD_WRITE: begin
              if (in_range) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(int'(in_stage) * ENTRIES_PER_STAGE + int'(in_slot));
                mem_wdata = '{valid: 1'b1,
                              dest:  VALUE_BITS'(in_dest),
                              src:   VALUE_BITS'(in_src),
                              len:   VALUE_BITS'(in_len)};
              end
            end
            CMD_XLATE: begin
              cur_next      = VALUE_BITS'(in_value);
              iss_addr_next = '0;
              iss_slot_next = '0;
              rd_pend_next  = 1'b0;
            end
            CMD_CLEAR: begin
              iss_addr_next = '0;
              lowest_next   = '1;
            end
            default: begin
              cur_next = cur;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Issue the next table read while the previous entry is compared.
        rd_pend_next = 1'b0;
        if (scan_issue) begin
          mem_re        = 1'b1;
          rd_pend_next  = 1'b1;
          rd_addr_next  = iss_addr;
          rd_slot_next  = iss_slot;
          iss_addr_next = iss_addr + AW1'(1);
          iss_slot_next = (iss_slot == SLW'(ENTRIES_PER_STAGE - 1)) ? '0
                                                                   : iss_slot + SLW'(1);
        end
        // A hit translates the value and skips the rest of its stage.
        if (hit) begin
          cur_next      = hit_value;
          rd_pend_next  = 1'b0;
          iss_addr_next = rd_addr - AW1'(rd_slot) + AW1'(ENTRIES_PER_STAGE);
          iss_slot_next = '0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_next  = 1'b1;
          out_mapped_next = cur;
          out_min_next    = min_new;
          lowest_next     = min_new;
        end
      end
      default: begin
        rd_pend_next = 1'b0;
      end
    endcase
  end

  // Entry table: one write or one read per cycle, read data registered.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_entry <= mem[iss_addr[AW-1:0]];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      iss_addr  <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
      lowest    <= '1;
    end else begin
      state     <= state_next;
      iss_addr  <= iss_addr_next;
      rd_pend   <= rd_pend_next;
      out_valid <= out_valid_next;
      lowest    <= lowest_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    iss_slot   <= iss_slot_next;
    rd_addr    <= rd_addr_next;
    rd_slot    <= rd_slot_next;
    cur        <= cur_next;
    out_mapped <= out_mapped_next;
    out_min    <= out_min_next;
  end

  // A table read is only in flight while a scan runs.
  a_rd_in_scan: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == ST_SCAN))
    else $error("table read pending outside a scan");

  // The scan pointer never runs past the end of the table.
  a_iss_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (iss_addr <= AW1'(DEPTH)))
    else $error("scan pointer beyond table");

  // A published minimum never exceeds the value it was published with.
  a_min_le: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_min <= out_mapped))
    else $error("running minimum above mapped value");

  // A clear request starts a sweep with the minimum back at all ones.
  a_clear_sweep: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (in_cmd == CMD_CLEAR)) |=> ((state == ST_CLEAR) && (lowest == '1)))
    else $error("clear request did not start a sweep");

endmodule

`default_nettype wire
